// ----- sv/bcdma_pkg.sv -----
package bcdma_pkg;

    localparam int BYTE_W      = 8;
    localparam int REG_W       = 16;
    localparam int IN_ADDR_W   = 16;
    localparam int COPIED_W    = 10;
    localparam int IDX_W       = 2;
    localparam int NUM_REGS    = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // bus action codes
    typedef enum logic [1:0] {
        ACT_REG_WR = 2'd0,
        ACT_START  = 2'd1,
        ACT_MEM_WR = 2'd2,
        ACT_MEM_RD = 2'd3
    } t_action;

    // work handed from front to back
    typedef enum logic [1:0] {
        KIND_NOP  = 2'd0,
        KIND_MWR  = 2'd1,
        KIND_MRD  = 2'd2,
        KIND_COPY = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [IN_ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]      data;
        logic [REG_W-1:0]       src;
        logic [REG_W-1:0]       len;
        logic [REG_W-1:0]       dst;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_beat;

endpackage

// ----- sv/bcdma_if.sv -----
interface bcdma_in_if;
    import bcdma_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           action;
    logic [IDX_W-1:0]     reg_index;
    logic [IN_ADDR_W-1:0] address;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, action, reg_index, address, data, input ready);
    modport sink   (input valid, action, reg_index, address, data, output ready);
endinterface

interface bcdma_out_if;
    import bcdma_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   read_data;
    logic [COPIED_W-1:0] copied;

    modport source (output valid, read_data, copied, input ready);
    modport sink   (input valid, read_data, copied, output ready);
endinterface

// ----- sv/byte_copy_dma_engine.sv -----
// Each beat passes front, queue and back; the result beat is registered.
// Reads also pass S_RD; a copy of N bytes runs in S_CP (N=0: from idle).
// Throughput: register and memory writes, one beat per cycle while results
// are taken; the single RAM port pair limits copies to one byte per cycle.
// Reset (sync, active low) clears DMA registers, toggles, queue and output;
// the byte memory is not cleared and must be written before it is read.
module byte_copy_dma_engine #(
    parameter int ADDR_BITS = 16,
    parameter int LEN_BITS  = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bcdma_in_if.sink   i_req,
    bcdma_out_if.source o_rsp
);
    import bcdma_pkg::*;

    // Front: holds the four DMA registers and their byte toggles, decodes each
    // beat and snapshots source/length/destination at the start beat, so
    // later register writes never disturb a copy already queued.
    t_cmd_beat push;
    logic      q_full;

    // Queue: short command FIFO; every accepted beat yields exactly one entry
    // so results come back in order.
    t_cmd_beat head;
    logic      pop;

    bcdma_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (q_full),
        .o_push  (push)
    );

    bcdma_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head)
    );

    // Back: owns the byte memory; runs writes, reads and the ascending copy
    // (overlapping ranges propagate through a one-entry forward path) and
    // drives the registered result beat.
    bcdma_back #(
        .ADDR_BITS (ADDR_BITS),
        .LEN_BITS  (LEN_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

// ----- sv/bcdma_ram.sv -----
module bcdma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/bcdma_fifo.sv -----
module bcdma_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bcdma_pkg::t_cmd_beat  i_push,
    output logic                  o_full,
    input  logic                  i_pop,
    output bcdma_pkg::t_cmd_beat  o_head
);
    import bcdma_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign do_push     = i_push.valid && !o_full;
    assign do_pop      = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- sv/bcdma_front.sv -----
module bcdma_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bcdma_in_if.sink             i_req,
    input  logic                 i_full,
    output bcdma_pkg::t_cmd_beat o_push
);
    import bcdma_pkg::*;

    logic [BYTE_W-1:0] r_lo [NUM_REGS];
    logic [BYTE_W-1:0] r_hi [NUM_REGS];
    logic [NUM_REGS-1:0] r_high_next;

    logic    accept;
    t_action act;

    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && !i_full;
    assign act         = t_action'(i_req.action);

    always_comb begin
        o_push.valid    = accept;
        o_push.cmd      = '0;
        o_push.cmd.kind = KIND_NOP;
        o_push.cmd.addr = i_req.address;
        o_push.cmd.data = i_req.data;
        o_push.cmd.src  = {r_hi[0], r_lo[0]};
        o_push.cmd.len  = {r_hi[1], r_lo[1]};
        o_push.cmd.dst  = {r_hi[2], r_lo[2]};
        unique case (act)
            ACT_REG_WR: o_push.cmd.kind = KIND_NOP;
            ACT_START:  o_push.cmd.kind = (i_req.data == '0) ? KIND_COPY : KIND_NOP;
            ACT_MEM_WR: o_push.cmd.kind = KIND_MWR;
            ACT_MEM_RD: o_push.cmd.kind = KIND_MRD;
            default:    o_push.cmd.kind = KIND_NOP;
        endcase
    end

    // register bytes land low first, then high, per-register toggle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_lo[i] <= '0;
                r_hi[i] <= '0;
            end
            r_high_next <= '0;
        end else if (accept) begin
            if (act == ACT_REG_WR) begin
                if (r_high_next[i_req.reg_index]) begin
                    r_hi[i_req.reg_index] <= i_req.data;
                end else begin
                    r_lo[i_req.reg_index] <= i_req.data;
                end
                r_high_next[i_req.reg_index] <= !r_high_next[i_req.reg_index];
            end else if (act == ACT_START && i_req.data == '0) begin
                r_high_next <= '0;
            end
        end
    end

endmodule

// ----- sv/bcdma_back.sv -----
module bcdma_back #(
    parameter int ADDR_BITS = 16,
    parameter int LEN_BITS  = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bcdma_pkg::t_cmd_beat i_head,
    output logic                 o_pop,
    bcdma_out_if.source          o_rsp
);
    import bcdma_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CP
    } t_state;

    t_state               r_state;
    logic [ADDR_BITS-1:0] r_src;
    logic [ADDR_BITS-1:0] r_dst;
    logic [LEN_BITS-1:0]  r_rd_left;
    logic [LEN_BITS-1:0]  r_len;
    logic                 r_wr_pend;
    logic                 r_byp_hit;
    logic [BYTE_W-1:0]    r_byp_data;
    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_read_data;
    logic [COPIED_W-1:0]  r_copied;

    logic                 out_free;
    logic                 rd_issue;
    logic                 wr_cp;
    logic                 cp_done;
    logic [LEN_BITS-1:0]  head_len;
    logic [BYTE_W-1:0]    cp_wdata;
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_wa;
    logic [BYTE_W-1:0]    ram_wd;
    logic [ADDR_BITS-1:0] ram_ra;
    logic [BYTE_W-1:0]    ram_q;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign o_pop    = (r_state == S_IDLE) && i_head.valid && out_free;
    assign head_len = LEN_BITS'(i_head.cmd.len);

    // copy: read of byte k overlaps write of byte k-1
    assign rd_issue = (r_state == S_CP) && (r_rd_left != '0);
    assign wr_cp    = (r_state == S_CP) && r_wr_pend;
    assign cp_done  = (r_state == S_CP) && (r_rd_left == '0) && !r_wr_pend;
    assign cp_wdata = r_byp_hit ? r_byp_data : ram_q;

    assign ram_ra = (r_state == S_IDLE) ? ADDR_BITS'(i_head.cmd.addr) : r_src;
    assign ram_we = wr_cp || (o_pop && i_head.cmd.kind == KIND_MWR);
    assign ram_wa = wr_cp ? r_dst : ADDR_BITS'(i_head.cmd.addr);
    assign ram_wd = wr_cp ? cp_wdata : i_head.cmd.data;

    bcdma_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (1 << ADDR_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_raddr (ram_ra),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_byp_hit   <= 1'b0;
        end else begin
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            // same-address read and write: forward the written byte
            r_byp_hit  <= rd_issue && wr_cp && (r_src == r_dst);
            r_byp_data <= cp_wdata;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        unique case (i_head.cmd.kind)
                            KIND_NOP, KIND_MWR: begin
                                r_out_valid <= 1'b1;
                                r_read_data <= '0;
                                r_copied    <= '0;
                            end
                            KIND_MRD: begin
                                r_state <= S_RD;
                            end
                            KIND_COPY: begin
                                if (head_len == '0) begin
                                    r_out_valid <= 1'b1;
                                    r_read_data <= '0;
                                    r_copied    <= '0;
                                end else begin
                                    r_src     <= ADDR_BITS'(i_head.cmd.src);
                                    r_dst     <= ADDR_BITS'(i_head.cmd.dst);
                                    r_rd_left <= head_len;
                                    r_len     <= head_len;
                                    r_wr_pend <= 1'b0;
                                    r_state   <= S_CP;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_RD: begin
                    r_out_valid <= 1'b1;
                    r_read_data <= ram_q;
                    r_copied    <= '0;
                    r_state     <= S_IDLE;
                end
                S_CP: begin
                    if (rd_issue) begin
                        r_src     <= r_src + 1'b1;
                        r_rd_left <= r_rd_left - 1'b1;
                    end
                    if (wr_cp) begin
                        r_dst <= r_dst + 1'b1;
                    end
                    r_wr_pend <= rd_issue;
                    if (cp_done) begin
                        r_out_valid <= 1'b1;
                        r_read_data <= '0;
                        r_copied    <= COPIED_W'(r_len);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_read_data;
    assign o_rsp.copied    = r_copied;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || cp_done) |-> !r_out_valid)
        else $error("result would overwrite an untaken beat");

    a_write_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_cp |-> $past(rd_issue))
        else $error("copy write without a preceding read");

    a_bypass_in_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp_hit |-> wr_cp)
        else $error("bypass hit outside a copy write");
`endif

endmodule
